// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by pose_sample_blend. Each macro samples on the rising
// edge of clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a whole property.
`define PSB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define PSB_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== sv/psb_pkg.sv =====
// ----------------------------------------------------------------------------
// psb_pkg
// Types, constants and helper functions for the pose sample blender.
// ----------------------------------------------------------------------------
`default_nettype none

package psb_pkg;

	// Quaternion components are signed Q1.14 in 16-bit lanes.
	localparam int ROT_BITS  = 16;
	localparam int FRAC_BITS = ROT_BITS - 2;

	// Default number of CORDIC steps.
	localparam int ANGLE_ITER_DEF = 16;

	// Reset value of the threshold register.
	localparam logic [14:0] THR_RESET = 15'd16383;

	// One in Q0.16 and in Q1.14.
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;
	localparam logic [18:0] DOT_ONE    = 19'd16384;

	// Arctangent of 2^-i in Q30.
	localparam logic [31:0] ATAN_TAB [0:31] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	// Input item.
	typedef struct packed {
		logic [63:0]        first_rotation;
		logic [63:0]        second_rotation;
		logic signed [31:0] first_pos_x;
		logic signed [31:0] first_pos_y;
		logic signed [31:0] first_pos_z;
		logic signed [31:0] second_pos_x;
		logic signed [31:0] second_pos_y;
		logic signed [31:0] second_pos_z;
		logic [16:0]        blend_weight;
	} psb_in_t;

	// Result item.
	typedef struct packed {
		logic [63:0]        blended_rotation;
		logic signed [31:0] blended_pos_x;
		logic signed [31:0] blended_pos_y;
		logic signed [31:0] blended_pos_z;
	} psb_out_t;

	// Per-item data that rides along the long slerp pipeline.
	typedef struct packed {
		logic [3:0][ROT_BITS-1:0] q1;
		logic [3:0][ROT_BITS:0]   q2n;
		logic [16:0]              a;
		logic [14:0]              c;
		logic [28:0]              x;
		logic                     use_lerp;
		logic [63:0]              lerp_rot;
		logic [2:0][31:0]         pos;
	} psb_carry_t;

	// Saturates a wide value to a 16-bit signed component.
	function automatic logic [15:0] psb_sat16(input logic signed [51:0] v);
		logic [15:0] r;
		if (v > 52'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -52'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Saturates a wide value to a 32-bit signed word.
	function automatic logic [31:0] psb_sat32(input logic signed [51:0] v);
		logic [31:0] r;
		if (v > 52'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -52'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/pose_sample_blend.sv =====
// ----------------------------------------------------------------------------
// pose_sample_blend
// Blends two pose samples: quaternion slerp for the rotation, linear
// interpolation for the position, all in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   An item is transferred at a rising edge with start high and busy low.
//   busy is always low, so a new item may be started in every cycle.
//   The result appears on result for exactly one cycle with done high.
//   Results leave in start order. The pipeline holds the 31-step square
//   root, the angle and sine CORDICs (ANGLE_ITERATIONS steps, 16 by default)
//   and the 16-step divider, each one stage per step.
//   The receiver cannot stall the block; every result must be taken when
//   done is high.
//   The threshold register is written through cfg_valid/cfg_data; cfg_ready
//   is always high. Write it only when no item is in flight.
//   Reset clears all valid bits and loads the threshold with 16383; items
//   in flight at reset are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pose_sample_blend
	import psb_pkg::*;
#(
	parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire psb_in_t     args,
	output logic             done,
	output psb_out_t         result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [14:0] cfg_data
);

	localparam int N       = ANGLE_ITERATIONS;
	localparam int SQ_N    = 31;
	localparam int DIV_N   = 16;
	localparam int CAR_N   = 53 + 2 * N;
	localparam int LATENCY = 58 + 2 * N;
	// Carry taps where each unit starts.
	localparam int C_VEC   = SQ_N;
	localparam int C_M1    = 31 + N;
	localparam int C_P1    = 33 + 2 * N;
	localparam int C_LAST  = CAR_N - 1;

	// Threshold register and configuration channel.
	logic [14:0] thr_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Front stages: lane products, dot product, sign fix and linear blends.
	logic                  v_s1, v_s2, v_s3, v_s4;
	logic signed [15:0]    l1 [0:3];
	logic signed [15:0]    l2 [0:3];
	logic signed [31:0]    fp [0:2];
	logic signed [31:0]    sp [0:2];
	logic signed [15:0]    q1_s1 [0:3];
	logic signed [15:0]    q2_s1 [0:3];
	logic signed [31:0]    pp_s1 [0:3];
	logic [16:0]           a_s1;
	logic signed [32:0]    dpos_s1 [0:2];
	logic signed [31:0]    p_s1 [0:2];
	logic signed [15:0]    q1_s2 [0:3];
	logic signed [15:0]    q2_s2 [0:3];
	logic signed [19:0]    dot_s2;
	logic signed [19:0]    dsum;
	logic [16:0]           a_s2;
	logic signed [50:0]    pprod_s2 [0:2];
	logic signed [31:0]    p_s2 [0:2];
	logic signed [15:0]    q1_s3 [0:3];
	logic signed [16:0]    q2n_s3 [0:3];
	logic [18:0]           dabs_s3;
	logic [16:0]           a_s3;
	logic [31:0]           pos_s3 [0:2];
	logic signed [15:0]    q1_s4 [0:3];
	logic signed [16:0]    q2n_s4 [0:3];
	logic signed [35:0]    lprod_s4 [0:3];
	logic [16:0]           a_s4;
	logic [14:0]           c_s4;
	logic                  use_lerp_s4;
	logic [31:0]           pos_s4 [0:2];

	// Lane and position views of the input item.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			l1[k] = $signed(args.first_rotation[(3 - k) * ROT_BITS +: ROT_BITS]);
			l2[k] = $signed(args.second_rotation[(3 - k) * ROT_BITS +: ROT_BITS]);
		end
		fp[0] = args.first_pos_x;
		fp[1] = args.first_pos_y;
		fp[2] = args.first_pos_z;
		sp[0] = args.second_pos_x;
		sp[1] = args.second_pos_y;
		sp[2] = args.second_pos_z;
	end

	// Sum of the four lane products, each floored to Q1.14.
	always_comb begin
		dsum = 20'(pp_s1[0] >>> FRAC_BITS) + 20'(pp_s1[1] >>> FRAC_BITS)
			+ 20'(pp_s1[2] >>> FRAC_BITS) + 20'(pp_s1[3] >>> FRAC_BITS);
	end

	// Front valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Front payload stages.
	always_ff @(posedge clk) begin
		// Stage 1: capture, lane products, weight clamp, position deltas.
		for (int k = 0; k < 4; k++) begin
			q1_s1[k] <= l1[k];
			q2_s1[k] <= l2[k];
			pp_s1[k] <= l1[k] * l2[k];
		end
		a_s1 <= (args.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : args.blend_weight;
		for (int k = 0; k < 3; k++) begin
			dpos_s1[k] <= 33'(sp[k]) - 33'(fp[k]);
			p_s1[k]    <= fp[k];
		end
		// Stage 2: dot product and position products.
		for (int k = 0; k < 4; k++) begin
			q1_s2[k] <= q1_s1[k];
			q2_s2[k] <= q2_s1[k];
		end
		dot_s2 <= dsum;
		a_s2   <= a_s1;
		for (int k = 0; k < 3; k++) begin
			pprod_s2[k] <= dpos_s1[k] * $signed({1'b0, a_s1});
			p_s2[k]     <= p_s1[k];
		end
		// Stage 3: take the shorter arc, finish the positions.
		for (int k = 0; k < 4; k++) begin
			q1_s3[k]  <= q1_s2[k];
			q2n_s3[k] <= dot_s2[19] ? -17'(q2_s2[k]) : 17'(q2_s2[k]);
		end
		dabs_s3 <= dot_s2[19] ? 19'(-dot_s2) : 19'(dot_s2);
		a_s3    <= a_s2;
		for (int k = 0; k < 3; k++) begin
			pos_s3[k] <= psb_sat32(52'(p_s2[k])
				+ ((52'(pprod_s2[k]) + 52'sd32768) >>> 16));
		end
		// Stage 4: path choice, capped cosine, rotation lerp products.
		for (int k = 0; k < 4; k++) begin
			q1_s4[k]    <= q1_s3[k];
			q2n_s4[k]   <= q2n_s3[k];
			lprod_s4[k] <= (18'(q2n_s3[k]) - 18'(q1_s3[k])) * $signed({1'b0, a_s3});
		end
		use_lerp_s4 <= dabs_s3 > {4'b0, thr_q};
		c_s4        <= (dabs_s3 > DOT_ONE) ? DOT_ONE[14:0] : dabs_s3[14:0];
		a_s4        <= a_s3;
		for (int k = 0; k < 3; k++) begin
			pos_s4[k] <= pos_s3[k];
		end
	end

	// Carry line: stage 5 fills the head, then it shifts one tap a cycle.
	psb_carry_t carry_s [0:CAR_N-1];
	logic       vld_s   [0:CAR_N-1];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			carry_s[0].q1[k]  <= q1_s4[k];
			carry_s[0].q2n[k] <= q2n_s4[k];
			carry_s[0].lerp_rot[(3 - k) * ROT_BITS +: ROT_BITS] <= psb_sat16(52'(q1_s4[k])
				+ ((52'(lprod_s4[k]) + 52'sd32768) >>> 16));
		end
		carry_s[0].a        <= a_s4;
		carry_s[0].c        <= c_s4;
		carry_s[0].x        <= 29'(30'd268435456 - 30'(c_s4 * c_s4));
		carry_s[0].use_lerp <= use_lerp_s4;
		for (int k = 0; k < 3; k++) begin
			carry_s[0].pos[k] <= pos_s4[k];
		end
		for (int g = 1; g < CAR_N; g++) begin
			carry_s[g] <= carry_s[g - 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < CAR_N; g++) begin
				vld_s[g] <= 1'b0;
			end
		end else begin
			vld_s[0] <= v_s4;
			for (int g = 1; g < CAR_N; g++) begin
				vld_s[g] <= vld_s[g - 1];
			end
		end
	end

	// Square root of 2^60 - c30^2, one result bit per stage.
	logic [34:0] sq_rem  [0:SQ_N-1];
	logic [30:0] sq_root [0:SQ_N-1];

	for (genvar j = 0; j < SQ_N; j++) begin : g_sq
		logic [61:0] vw;
		logic [34:0] r_in;
		logic [30:0] rt_in;
		logic [34:0] acc;
		logic [34:0] trial;

		if (j == 0) begin : g_first
			assign r_in  = '0;
			assign rt_in = '0;
		end else begin : g_next
			assign r_in  = sq_rem[j - 1];
			assign rt_in = sq_root[j - 1];
		end

		assign vw    = {1'b0, carry_s[j].x, 32'b0};
		assign acc   = {r_in[32:0], vw[61 - 2 * j -: 2]};
		assign trial = {2'b0, rt_in, 2'b01};

		always_ff @(posedge clk) begin
			if (acc >= trial) begin
				sq_rem[j]  <= acc - trial;
				sq_root[j] <= {rt_in[29:0], 1'b1};
			end else begin
				sq_rem[j]  <= acc;
				sq_root[j] <= {rt_in[29:0], 1'b0};
			end
		end
	end

	// Angle of (c30, s30) by CORDIC vectoring, one step per stage.
	logic signed [33:0] vx [0:N-1];
	logic signed [33:0] vy [0:N-1];
	logic signed [33:0] vz [0:N-1];

	for (genvar i = 0; i < N; i++) begin : g_vec
		logic signed [33:0] x_in, y_in, z_in;
		logic signed [33:0] at;

		if (i == 0) begin : g_first
			assign x_in = $signed({3'b0, carry_s[C_VEC].c, 16'b0});
			assign y_in = $signed({3'b0, sq_root[SQ_N - 1]});
			assign z_in = '0;
		end else begin : g_next
			assign x_in = vx[i - 1];
			assign y_in = vy[i - 1];
			assign z_in = vz[i - 1];
		end

		assign at = $signed({2'b0, ATAN_TAB[i]});

		always_ff @(posedge clk) begin
			if (!y_in[33]) begin
				vx[i] <= x_in + (y_in >>> i);
				vy[i] <= y_in - (x_in >>> i);
				vz[i] <= z_in + at;
			end else begin
				vx[i] <= x_in - (y_in >>> i);
				vy[i] <= y_in + (x_in >>> i);
				vz[i] <= z_in - at;
			end
		end
	end

	// Weighted angle: product, then the three sine arguments.
	logic signed [33:0] th_m1;
	logic signed [51:0] prod_m1;
	logic signed [37:0] ang_m2 [0:2];
	logic signed [35:0] at_m1;

	assign at_m1 = prod_m1[51:16];

	always_ff @(posedge clk) begin
		th_m1     <= vz[N - 1];
		prod_m1   <= vz[N - 1] * $signed({1'b0, carry_s[C_M1].a});
		ang_m2[0] <= 38'(th_m1) - 38'(at_m1);
		ang_m2[1] <= 38'(at_m1);
		ang_m2[2] <= 38'(th_m1);
	end

	// Three sines by CORDIC rotation, in parallel, one step per stage.
	logic signed [33:0] sx [0:2][0:N-1];
	logic signed [33:0] sy [0:2][0:N-1];
	logic signed [37:0] sz [0:2][0:N-1];

	for (genvar u = 0; u < 3; u++) begin : g_sin
		for (genvar i = 0; i < N; i++) begin : g_step
			logic signed [33:0] x_in, y_in;
			logic signed [37:0] z_in;
			logic signed [37:0] at;

			if (i == 0) begin : g_first
				assign x_in = 34'sd1073741824;
				assign y_in = '0;
				assign z_in = ang_m2[u];
			end else begin : g_next
				assign x_in = sx[u][i - 1];
				assign y_in = sy[u][i - 1];
				assign z_in = sz[u][i - 1];
			end

			assign at = $signed({6'b0, ATAN_TAB[i]});

			always_ff @(posedge clk) begin
				if (!z_in[37]) begin
					sx[u][i] <= x_in - (y_in >>> i);
					sy[u][i] <= y_in + (x_in >>> i);
					sz[u][i] <= z_in - at;
				end else begin
					sx[u][i] <= x_in + (y_in >>> i);
					sy[u][i] <= y_in - (x_in >>> i);
					sz[u][i] <= z_in + at;
				end
			end
		end
	end

	// Numerators and divisor setup.
	logic signed [33:0] kx, kz, kd;
	logic signed [49:0] m1_p1 [0:3];
	logic signed [50:0] m2_p1 [0:3];
	logic signed [33:0] dv_p1;
	logic [51:0]        mag_p2 [0:3];
	logic               neg_p2 [0:3];
	logic [31:0]        dvp_p2;
	logic               bad_p2;
	logic [47:0]        rem_p3 [0:3];
	logic               ovf_p3 [0:3];
	logic               neg_p3 [0:3];
	logic [31:0]        dvp_p3;
	logic               bad_p3;
	logic signed [51:0] num [0:3];

	assign kx = sy[0][N - 1] >>> 1;
	assign kz = sy[1][N - 1] >>> 1;
	assign kd = sy[2][N - 1] >>> 1;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			num[k] = 52'(m1_p1[k]) + 52'(m2_p1[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			m1_p1[k]  <= $signed(carry_s[C_P1].q1[k]) * kx;
			m2_p1[k]  <= $signed(carry_s[C_P1].q2n[k]) * kz;
			mag_p2[k] <= num[k][51] ? 52'(-num[k]) : 52'(num[k]);
			neg_p2[k] <= num[k][51];
			ovf_p3[k] <= mag_p2[k] >= {4'b0, dvp_p2, 16'b0};
			rem_p3[k] <= mag_p2[k][47:0];
			neg_p3[k] <= neg_p2[k];
		end
		dv_p1  <= kd;
		dvp_p2 <= dv_p1[31:0];
		bad_p2 <= dv_p1[33] || (dv_p1 == '0);
		dvp_p3 <= dvp_p2;
		bad_p3 <= bad_p2;
	end

	// Restoring divider, one quotient bit per stage.
	logic [47:0] dv_rem [0:DIV_N-1][0:3];
	logic [15:0] dv_qt  [0:DIV_N-1][0:3];
	logic        dv_neg [0:DIV_N-1][0:3];
	logic        dv_ovf [0:DIV_N-1][0:3];
	logic [31:0] dv_dvp [0:DIV_N-1];
	logic        dv_bad [0:DIV_N-1];

	for (genvar j = 0; j < DIV_N; j++) begin : g_div
		logic [47:0] tr;
		logic [31:0] dvp_in;
		logic        bad_in;

		if (j == 0) begin : g_first
			assign dvp_in = dvp_p3;
			assign bad_in = bad_p3;
		end else begin : g_next
			assign dvp_in = dv_dvp[j - 1];
			assign bad_in = dv_bad[j - 1];
		end

		assign tr = {16'b0, dvp_in} << (DIV_N - 1 - j);

		always_ff @(posedge clk) begin
			dv_dvp[j] <= dvp_in;
			dv_bad[j] <= bad_in;
		end

		for (genvar k = 0; k < 4; k++) begin : g_lane
			logic [47:0] r_in;
			logic [15:0] q_in;
			logic        n_in, o_in;

			if (j == 0) begin : g_first
				assign r_in = rem_p3[k];
				assign q_in = '0;
				assign n_in = neg_p3[k];
				assign o_in = ovf_p3[k];
			end else begin : g_next
				assign r_in = dv_rem[j - 1][k];
				assign q_in = dv_qt[j - 1][k];
				assign n_in = dv_neg[j - 1][k];
				assign o_in = dv_ovf[j - 1][k];
			end

			always_ff @(posedge clk) begin
				dv_neg[j][k] <= n_in;
				dv_ovf[j][k] <= o_in;
				if (r_in >= tr) begin
					dv_rem[j][k] <= r_in - tr;
					dv_qt[j][k]  <= {q_in[14:0], 1'b1};
				end else begin
					dv_rem[j][k] <= r_in;
					dv_qt[j][k]  <= {q_in[14:0], 1'b0};
				end
			end
		end
	end

	// Output stage: sign, saturate, choose slerp or lerp, pack.
	logic [15:0] sl [0:3];
	logic [16:0] nq [0:3];
	logic [63:0] rot_sel;
	logic        pick_lerp;
	logic        done_q;
	psb_out_t    result_q;

	assign pick_lerp = carry_s[C_LAST].use_lerp || dv_bad[DIV_N - 1];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			nq[k] = 17'd0 - {1'b0, dv_qt[DIV_N - 1][k]};
			if (dv_ovf[DIV_N - 1][k]) begin
				sl[k] = dv_neg[DIV_N - 1][k] ? 16'h8000 : 16'h7FFF;
			end else if (dv_neg[DIV_N - 1][k]) begin
				sl[k] = (dv_qt[DIV_N - 1][k] > 16'd32768) ? 16'h8000 : nq[k][15:0];
			end else begin
				sl[k] = (dv_qt[DIV_N - 1][k] > 16'd32767) ? 16'h7FFF
					: dv_qt[DIV_N - 1][k];
			end
		end
		rot_sel = {sl[0], sl[1], sl[2], sl[3]};
		if (pick_lerp) begin
			rot_sel = carry_s[C_LAST].lerp_rot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[C_LAST];
		end
	end

	always_ff @(posedge clk) begin
		result_q.blended_rotation <= rot_sel;
		result_q.blended_pos_x    <= carry_s[C_LAST].pos[0];
		result_q.blended_pos_y    <= carry_s[C_LAST].pos[1];
		result_q.blended_pos_z    <= carry_s[C_LAST].pos[2];
	end

	assign done   = done_q;
	assign result = result_q;

	// Every result traces back to an earlier start transfer.
	`PSB_ASSERT(a_done_has_start, done_q |-> $past(start, LATENCY), "result without a start transfer")
	// Every start transfer produces a result.
	`PSB_ASSERT(a_start_gives_done, start |-> ##LATENCY done_q, "start transfer lost in the pipeline")
	// The cosine that enters the angle CORDIC never exceeds one.
	`PSB_IMPLY(a_cos_capped, vld_s[C_VEC], carry_s[C_VEC].c <= DOT_ONE[14:0], "cosine above one")

endmodule

`default_nettype wire
